/* rtl/fqsr_pkg.sv */
// ----------------------------------------------------------------------------
// fqsr_pkg
// Shared types and constants for the ring queue with search and reverse.
// ----------------------------------------------------------------------------
package fqsr_pkg;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_SRCH = 2'd2,
        OP_REV  = 2'd3
    } func_t;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 112;

    localparam logic signed [POS_W-1:0] FOUND_NONE = -5'sd1;

endpackage

/* rtl/fqsr_ram.sv */
// ----------------------------------------------------------------------------
// fqsr_ram
// Entry store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module fqsr_ram #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32,
    localparam int unsigned ADDR_W    = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [ADDR_W-1:0]     rd0_addr,
    output logic [DATA_WIDTH-1:0] rd0_data,
    input  logic [ADDR_W-1:0]     rd1_addr,
    output logic [DATA_WIDTH-1:0] rd1_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd0_data <= mem[rd0_addr];
        rd1_data <= mem[rd1_addr];
    end

endmodule

/* rtl/fifo_queue_with_search_reverse_unit.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_search_reverse_unit
// Ring queue of DEPTH words with enqueue, dequeue, search and reverse.
// ----------------------------------------------------------------------------
// One request is handled at a time; the result register lets the next request
// in while the previous result waits. Each result carries the entry count and
// the front and back entries, fetched through the registered store read ports
// after the operation. Search streams one entry per cycle through a read port
// and stops early on a match. Reverse swaps one pair at a time over the single
// write port, with no swap for fewer than two entries. A finished request
// holds the unit while the previous result is still waiting to be taken.
// Enqueue into a full queue and dequeue from an empty one are refused with
// tuser low.
module fifo_queue_with_search_reverse_unit
    import fqsr_pkg::*;
#(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // item_value
    input  logic [FUNC_W-1:0]   s_axis_tuser,   // func
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // removed_value, found_position, entry_count, front_value, back_value, zero pad
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tuser    // accepted
);

    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W  = CNT_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DEQ, ST_SRCH, ST_REV_RD, ST_REV_WA, ST_REV_WB,
        ST_FRONT, ST_BACK, ST_FIN
    } state_t;

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
        wrap_inc = (a == ADDR_W'(DEPTH - 1)) ? '0 : a + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] a);
        wrap_dec = (a == '0) ? ADDR_W'(DEPTH - 1) : a - ADDR_W'(1);
    endfunction

    state_t                   state_reg, state_next;
    logic [ADDR_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0]    key_reg, key_next;
    logic                     acc_reg, acc_next;
    logic [DATA_WIDTH-1:0]    removed_reg, removed_next;
    logic signed [POS_W-1:0]  found_reg, found_next;
    logic [CNT_W-1:0]         srch_idx_reg, srch_idx_next;
    logic [ADDR_W-1:0]        srch_addr_reg, srch_addr_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic [CNT_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]        a_reg, a_next;
    logic [ADDR_W-1:0]        b_reg, b_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [DATA_WIDTH-1:0]    hold_reg, hold_next;
    logic [DATA_WIDTH-1:0]    front_reg, front_next;

    logic                     m_valid_reg, m_valid_next;
    logic                     out_acc_reg, out_acc_next;
    logic [VALUE_W-1:0]       out_removed_reg, out_removed_next;
    logic signed [POS_W-1:0]  out_found_reg, out_found_next;
    logic [COUNT_W-1:0]       out_count_reg, out_count_next;
    logic [VALUE_W-1:0]       out_front_reg, out_front_next;
    logic [VALUE_W-1:0]       out_back_reg, out_back_next;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [DATA_WIDTH-1:0]    wr_data;
    logic [ADDR_W-1:0]        rd0_addr;
    logic [ADDR_W-1:0]        rd1_addr;
    logic [DATA_WIDTH-1:0]    rd0_data;
    logic [DATA_WIDTH-1:0]    rd1_data;

    logic [SUM_W-1:0]         end_sum;
    logic [ADDR_W-1:0]        end_slot;
    logic [ADDR_W-1:0]        tail;
    logic                     s_fire;
    logic                     out_free;
    logic                     srch_issue;
    logic                     srch_hit;
    logic                     empty;
    logic                     full;

    fqsr_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd0_addr (rd0_addr),
        .rd0_data (rd0_data),
        .rd1_addr (rd1_addr),
        .rd1_data (rd1_data)
    );

    // slot past the newest entry, and the newest entry itself
    assign end_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign end_slot = (end_sum >= SUM_W'(DEPTH)) ? ADDR_W'(end_sum - SUM_W'(DEPTH))
                                                 : ADDR_W'(end_sum);
    assign tail     = wrap_dec(end_slot);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign srch_issue    = (srch_idx_reg < count_reg);
    assign srch_hit      = cmp_vld_reg && (rd0_data == key_reg);

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        key_next         = key_reg;
        acc_next         = acc_reg;
        removed_next     = removed_reg;
        found_next       = found_reg;
        srch_idx_next    = srch_idx_reg;
        srch_addr_next   = srch_addr_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        rem_next         = rem_reg;
        hold_next        = hold_reg;
        front_next       = front_reg;
        m_valid_next     = m_valid_reg;
        out_acc_next     = out_acc_reg;
        out_removed_next = out_removed_reg;
        out_found_next   = out_found_reg;
        out_count_next   = out_count_reg;
        out_front_next   = out_front_reg;
        out_back_next    = out_back_reg;
        wr_en            = 1'b0;
        wr_addr          = end_slot;
        wr_data          = key_reg;
        rd0_addr         = head_reg;
        rd1_addr         = b_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    key_next     = DATA_WIDTH'(s_axis_tdata);
                    acc_next     = 1'b1;
                    removed_next = '0;
                    found_next   = FOUND_NONE;
                    unique case (func_t'(s_axis_tuser))
                        OP_ENQ: begin
                            if (full) begin
                                acc_next = 1'b0;
                            end else begin
                                wr_en      = 1'b1;
                                wr_data    = DATA_WIDTH'(s_axis_tdata);
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = ST_FRONT;
                        end
                        OP_DEQ: begin
                            if (empty) begin
                                acc_next   = 1'b0;
                                state_next = ST_FRONT;
                            end else begin
                                head_next  = wrap_inc(head_reg);
                                count_next = count_reg - CNT_W'(1);
                                state_next = ST_DEQ;
                            end
                        end
                        OP_SRCH: begin
                            srch_idx_next  = '0;
                            srch_addr_next = head_reg;
                            state_next     = ST_SRCH;
                        end
                        OP_REV: begin
                            a_next     = head_reg;
                            b_next     = tail;
                            rem_next   = count_reg >> 1;
                            state_next = (count_reg < CNT_W'(2)) ? ST_FRONT : ST_REV_RD;
                        end
                        default: begin
                            state_next = ST_FRONT;
                        end
                    endcase
                end
            end
            ST_DEQ: begin
                // read of the old head lands now; new head read goes out
                removed_next = rd0_data;
                state_next   = ST_BACK;
            end
            ST_SRCH: begin
                rd0_addr = srch_addr_reg;
                if (srch_hit) begin
                    found_next = POS_W'(cmp_idx_reg);
                    state_next = ST_FRONT;
                end else if (!srch_issue && !cmp_vld_reg) begin
                    state_next = ST_FRONT;
                end else if (srch_issue) begin
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = srch_idx_reg;
                    srch_idx_next  = srch_idx_reg + CNT_W'(1);
                    srch_addr_next = wrap_inc(srch_addr_reg);
                end
            end
            ST_REV_RD: begin
                rd0_addr   = a_reg;
                rd1_addr   = b_reg;
                state_next = ST_REV_WA;
            end
            ST_REV_WA: begin
                wr_en     = 1'b1;
                wr_addr   = a_reg;
                wr_data   = rd1_data;
                hold_next = rd0_data;
                rd0_addr  = wrap_inc(a_reg);
                rd1_addr  = wrap_dec(b_reg);
                state_next = ST_REV_WB;
            end
            ST_REV_WB: begin
                // next pair is read while the current one finishes
                wr_en    = 1'b1;
                wr_addr  = b_reg;
                wr_data  = hold_reg;
                rd0_addr = wrap_inc(a_reg);
                rd1_addr = wrap_dec(b_reg);
                a_next   = wrap_inc(a_reg);
                b_next   = wrap_dec(b_reg);
                rem_next = rem_reg - CNT_W'(1);
                state_next = (rem_reg == CNT_W'(1)) ? ST_FRONT : ST_REV_WA;
            end
            ST_FRONT: begin
                rd0_addr   = head_reg;
                state_next = ST_BACK;
            end
            ST_BACK: begin
                front_next = rd0_data;
                rd0_addr   = tail;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                rd0_addr = tail;
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    out_acc_next     = acc_reg;
                    out_removed_next = VALUE_W'(removed_reg);
                    out_found_next   = found_reg;
                    out_count_next   = COUNT_W'(count_reg);
                    out_front_next   = empty ? '0 : VALUE_W'(front_reg);
                    out_back_next    = empty ? '0 : VALUE_W'(rd0_data);
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg         <= key_next;
        acc_reg         <= acc_next;
        removed_reg     <= removed_next;
        found_reg       <= found_next;
        srch_idx_reg    <= srch_idx_next;
        srch_addr_reg   <= srch_addr_next;
        cmp_idx_reg     <= cmp_idx_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        rem_reg         <= rem_next;
        hold_reg        <= hold_next;
        front_reg       <= front_next;
        out_acc_reg     <= out_acc_next;
        out_removed_reg <= out_removed_next;
        out_found_reg   <= out_found_next;
        out_count_reg   <= out_count_next;
        out_front_reg   <= out_front_next;
        out_back_reg    <= out_back_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_acc_reg;
    assign m_axis_tdata  = {6'd0, out_back_reg, out_front_reg, out_count_reg,
                            out_found_reg, out_removed_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < ADDR_W'(DEPTH - 1) || head_reg == ADDR_W'(DEPTH - 1))
        else $error("head pointer outside the ring");

    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_axis_tuser == OP_ENQ && !full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("enqueue did not add one entry");

    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_axis_tuser == OP_DEQ && !empty |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("dequeue did not remove one entry");
`endif

endmodule

/* bench/fifo_queue_with_search_reverse_unit_tb.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_search_reverse_unit_tb
// Self-checking bench for the ring queue with search and reverse. A shadow
// queue predicts every result at the moment the request transfer happens,
// and each result transfer is checked field by field against the oldest
// prediction. Directed cases cover the empty and full queue, duplicate keys
// and the data extremes. Random traffic follows, biased in turn towards
// filling and draining, with idle bursts on both sides, one long stall of
// the result side and paused bursts. The run ends with idle-free streaming.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_reverse_unit_tb;
    import fqsr_pkg::*;

    localparam int DEPTH = 16;

    typedef struct {
        logic                    accepted;
        logic [VALUE_W-1:0]      removed;
        logic signed [POS_W-1:0] position;
        logic [COUNT_W-1:0]      count;
        logic [VALUE_W-1:0]      front;
        logic [VALUE_W-1:0]      back;
    } queue_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [FUNC_W-1:0]   s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    // shadow copy of the queue
    logic [VALUE_W-1:0] shadow_mem [DEPTH];
    int                 shadow_head;
    int                 shadow_count;

    queue_result_t pending_results [$];
    queue_result_t got_result;
    queue_result_t want_result;

    bit src_gaps;
    bit sink_stalls;
    int sink_hold;
    int error_count;
    int op_count [4];
    int refused_count;
    int search_hits;
    int full_hits;
    int checked_count;

    fifo_queue_with_search_reverse_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int slot_at(int pos);
        return (shadow_head + pos) % DEPTH;
    endfunction

    function automatic queue_result_t apply_queue_op(func_t op, logic [VALUE_W-1:0] value);
        queue_result_t r;
        logic [VALUE_W-1:0] swap;
        int a;
        int b;
        r.accepted = 1'b1;
        r.removed  = '0;
        r.position = FOUND_NONE;
        case (op)
            OP_ENQ: begin
                if (shadow_count == DEPTH) begin
                    r.accepted = 1'b0;
                    full_hits++;
                end else begin
                    shadow_mem[slot_at(shadow_count)] = value;
                    shadow_count++;
                end
            end
            OP_DEQ: begin
                if (shadow_count == 0) begin
                    r.accepted = 1'b0;
                end else begin
                    r.removed   = shadow_mem[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end
            end
            OP_SRCH: begin
                // scan downwards so the match nearest the front wins
                for (int i = shadow_count - 1; i >= 0; i--) begin
                    if (shadow_mem[slot_at(i)] == value) r.position = 5'(i);
                end
                if (r.position != FOUND_NONE) search_hits++;
            end
            default: begin
                for (int i = 0; i < shadow_count / 2; i++) begin
                    a = slot_at(i);
                    b = slot_at(shadow_count - 1 - i);
                    swap          = shadow_mem[a];
                    shadow_mem[a] = shadow_mem[b];
                    shadow_mem[b] = swap;
                end
            end
        endcase
        if (!r.accepted) refused_count++;
        r.count = 5'(shadow_count);
        if (shadow_count == 0) begin
            r.front = '0;
            r.back  = '0;
        end else begin
            r.front = shadow_mem[shadow_head];
            r.back  = shadow_mem[slot_at(shadow_count - 1)];
        end
        op_count[op]++;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return VALUE_W'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // mostly keys that are held, so that searches hit
    function automatic logic [VALUE_W-1:0] random_key();
        if (shadow_count > 0 && $urandom_range(0, 9) < 7)
            return shadow_mem[slot_at($urandom_range(0, shadow_count - 1))];
        return random_value();
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input func_t op, input logic [VALUE_W-1:0] value);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(apply_queue_op(op, value));
        @(negedge aclk);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void check_field(string name, logic [VALUE_W-1:0] want,
                                        logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_result.accepted = m_axis_tuser;
            got_result.removed  = m_axis_tdata[31:0];
            got_result.position = m_axis_tdata[36:32];
            got_result.count    = m_axis_tdata[41:37];
            got_result.front    = m_axis_tdata[73:42];
            got_result.back     = m_axis_tdata[105:74];
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                error_count++;
            end else begin
                want_result = pending_results.pop_front();
                checked_count++;
                check_field("accepted", 32'(want_result.accepted), 32'(got_result.accepted));
                check_field("removed_value", want_result.removed, got_result.removed);
                check_field("found_position", 32'(unsigned'(want_result.position)),
                            32'(unsigned'(got_result.position)));
                check_field("entry_count", 32'(want_result.count), 32'(got_result.count));
                check_field("front_value", want_result.front, got_result.front);
                check_field("back_value", want_result.back, got_result.back);
            end
        end
    end

    // result side: random stalls, or one long hold when asked
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
                for (int n = 1; n < sink_hold; n++) @(negedge aclk);
                sink_hold = 0;
            end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic test_empty_queue();
        send_item(OP_DEQ, '1);
        send_item(OP_SRCH, '0);
        send_item(OP_REV, '0);
        send_item(OP_ENQ, '0);
        send_item(OP_REV, '1);
    endtask

    task automatic test_full_queue();
        logic [VALUE_W-1:0] fill_vals [15] = '{
            32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
            32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'h1234_5678,
            32'hFFFF_FFFE, 32'h0000_0002, 32'hDEAD_BEEF, 32'h0F0F_0F0F,
            32'hF0F0_F0F0, 32'h0000_0000, 32'hCAFE_F00D
        };
        foreach (fill_vals[i]) send_item(OP_ENQ, fill_vals[i]);
        // refused when full
        send_item(OP_ENQ, 32'h1357_9BDF);
        // duplicates: first one wins
        send_item(OP_SRCH, 32'h0000_0001);
        send_item(OP_SRCH, 32'h0000_0000);
        send_item(OP_SRCH, 32'h1357_9BDF);
        send_item(OP_REV, '0);
        send_item(OP_DEQ, '0);
    endtask

    task automatic test_random_traffic(input int items, input int enq_weight);
        func_t op;
        int    pick;
        repeat (items) begin
            pick = $urandom_range(0, 99);
            if (pick < enq_weight)
                op = OP_ENQ;
            else if (pick < enq_weight + (100 - enq_weight) / 2)
                op = OP_DEQ;
            else if (pick < 90)
                op = OP_SRCH;
            else
                op = OP_REV;
            send_item(op, (op == OP_SRCH) ? random_key() : random_value());
        end
    endtask

    task automatic test_output_backpressure();
        bit gaps_saved;
        gaps_saved = src_gaps;
        src_gaps   = 1'b0;
        sink_hold  = 120;
        test_random_traffic(40, 50);
        src_gaps   = gaps_saved;
    endtask

    task automatic test_paused_bursts();
        repeat (5) begin
            test_random_traffic(20, 45);
            wait_for_drain();
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ENQ;
        src_gaps      = 1'b0;
        sink_stalls   = 1'b0;
        sink_hold     = 0;
        error_count   = 0;
        refused_count = 0;
        search_hits   = 0;
        full_hits     = 0;
        checked_count = 0;
        shadow_head   = 0;
        shadow_count  = 0;
        foreach (op_count[i]) op_count[i] = 0;
        foreach (shadow_mem[i]) shadow_mem[i] = '0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_queue();
        test_full_queue();
        wait_for_drain();

        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        test_random_traffic(350, 65);
        test_random_traffic(350, 30);
        test_random_traffic(350, 45);
        test_output_backpressure();
        test_paused_bursts();

        // no idling from here on
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        test_random_traffic(200, 45);

        wait_for_drain();
        repeat (40) @(posedge aclk);

        $display("covered %0d transfers: %0d enqueue (%0d into a full queue), %0d dequeue,",
                 checked_count, op_count[OP_ENQ], full_hits, op_count[OP_DEQ]);
        $display("%0d search (%0d hits), %0d reverse, %0d refused in all",
                 op_count[OP_SRCH], search_hits, op_count[OP_REV], refused_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
